FILE: rtl/dbes_pkg.sv
// Shared types, event codes and register indexes for the debounced input
// event scanner. No dependencies.
`default_nettype none
package dbes_pkg;

    localparam int NUM_CH   = 8;
    localparam int NUM_EV   = NUM_CH + 1;   // channels, then overload
    localparam int EV_IDX_W = $clog2(NUM_EV);

    // Event codes
    localparam logic [3:0] EV_REQ_GROUND    = 4'd0;
    localparam logic [3:0] EV_REQ_FLOOR2    = 4'd1;
    localparam logic [3:0] EV_EMERG_ON      = 4'd2;
    localparam logic [3:0] EV_EMERG_OFF     = 4'd3;
    localparam logic [3:0] EV_DOOR_CLOSED   = 4'd4;
    localparam logic [3:0] EV_DOOR_OPEN     = 4'd5;
    localparam logic [3:0] EV_ARRIVE_GROUND = 4'd6;
    localparam logic [3:0] EV_ARRIVE_FLOOR2 = 4'd7;
    localparam logic [3:0] EV_OVERLOAD_ON   = 4'd8;
    localparam logic [3:0] EV_OVERLOAD_OFF  = 4'd9;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [1:0] CFG_HYSTERESIS = 2'd2;

    // Channels that also report a release (stable level back to 1)
    localparam logic [NUM_CH-1:0] CH_REPORTS_HIGH = 8'b0011_0000;

    // Events raised by one scan, handed to the event queue
    typedef struct packed {
        logic [NUM_EV-1:0]  mask;     // one bit per event source
        logic [NUM_CH-1:0]  levels;   // new stable level per channel
        logic               ovl_on;   // overload event direction
        logic signed [31:0] load;     // load sample for the overload event
    } t_scan_events;

    // Event code of a channel's stable edge to the given level
    function automatic logic [3:0] chan_code(input logic [2:0] ch, input logic lvl);
        logic [3:0] code;
        case (ch)
            3'd0, 3'd1: code = EV_REQ_GROUND;
            3'd2, 3'd3: code = EV_REQ_FLOOR2;
            3'd4:       code = lvl ? EV_EMERG_OFF : EV_EMERG_ON;
            3'd5:       code = lvl ? EV_DOOR_OPEN : EV_DOOR_CLOSED;
            3'd6:       code = EV_ARRIVE_GROUND;
            3'd7:       code = EV_ARRIVE_FLOOR2;
            default:    code = EV_REQ_GROUND;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/dbes_chan.sv
// One debounce lane: candidate level, stable level and change time.
// Depends on nothing outside itself.
`default_nettype none
module dbes_chan (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_level,
    input  wire logic [31:0] i_now,
    input  wire logic [15:0] i_debounce,
    output logic             o_edge,
    output logic             o_stable
);
    logic        r_cand, r_stable;
    logic [31:0] r_time;
    logic [31:0] elapsed;
    logic        cand_change;

    assign cand_change = (i_level != r_cand);
    assign elapsed     = i_now - r_time;     // wraps mod 2^32
    assign o_edge      = !cand_change && (i_level != r_stable)
                         && (elapsed >= {16'd0, i_debounce});
    assign o_stable    = i_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand   <= 1'b1;
            r_stable <= 1'b1;
            r_time   <= '0;
        end else if (i_en) begin
            if (cand_change) begin
                r_cand <= i_level;
                r_time <= i_now;
            end else if (o_edge) begin
                r_stable <= i_level;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/dbes_ovl.sv
// Overload detector with hysteresis on the load sample.
// Depends on nothing outside itself.
`default_nettype none
module dbes_ovl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_load_ready,
    input  wire logic signed [31:0] i_load,
    input  wire logic        [23:0] i_thr,
    input  wire logic        [15:0] i_hyst,
    output logic                    o_on,
    output logic                    o_off
);
    logic               r_active;
    logic signed [33:0] grams, thr, off;

    assign grams = 34'(i_load);
    assign thr   = $signed({10'd0, i_thr});
    assign off   = thr - $signed({18'd0, i_hyst});

    assign o_on  = i_load_ready && !r_active && (grams >= thr);
    assign o_off = i_load_ready &&  r_active && (grams <  off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_en) begin
            if (o_on)       r_active <= 1'b1;
            else if (o_off) r_active <= 1'b0;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/dbes_evq.sv
// Event queue: holds the events of one scan and sends them out one per
// cycle while ready, lowest source first, via an output register. Uses dbes_pkg.
`default_nettype none
module dbes_evq
    import dbes_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,      // scan processed this cycle
    input  wire t_scan_events       i_scan,
    output logic                    o_free,      // queue can take a scan now
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic             [3:0]  o_code,
    output logic signed      [31:0] o_value,
    output logic                    o_last
);
    logic [NUM_EV-1:0]   r_pend, n_pend, lowest, pend_after;
    logic [NUM_CH-1:0]   r_levels;
    logic                r_ovl_on;
    logic signed [31:0]  r_load;
    logic                r_valid;
    logic                out_load;
    logic [EV_IDX_W-1:0] idx;
    logic [3:0]          code;

    assign out_load   = (|r_pend) && (!r_valid || i_ready);
    assign lowest     = r_pend & (~r_pend + 1'b1);
    assign pend_after = out_load ? (r_pend & ~lowest) : r_pend;
    assign o_free     = (pend_after == '0);
    assign n_pend     = i_load ? i_scan.mask : pend_after;

    always_comb begin
        idx = '0;
        for (int i = NUM_EV - 1; i >= 0; i--) begin
            if (r_pend[i]) idx = EV_IDX_W'(i);
        end
    end

    always_comb begin
        if (idx == EV_IDX_W'(NUM_CH))
            code = r_ovl_on ? EV_OVERLOAD_ON : EV_OVERLOAD_OFF;
        else
            code = chan_code(idx[2:0], r_levels[idx[2:0]]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (out_load)     r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_levels <= i_scan.levels;
            r_ovl_on <= i_scan.ovl_on;
            r_load   <= i_scan.load;
        end
        if (out_load) begin
            o_code  <= code;
            o_value <= (idx == EV_IDX_W'(NUM_CH)) ? r_load : 32'sd0;
            o_last  <= (pend_after == '0);
        end
    end

    assign o_valid = r_valid;
endmodule
`default_nettype wire

FILE: rtl/debounced_input_event_scanner_unit.sv
// Top level of the debounced input event scanner: input register, eight
// debounce lanes, overload detector and event queue. Uses dbes_pkg,
// dbes_chan, dbes_ovl and dbes_evq.
//
// Usage:
//  - Scan channel (i_in_valid / o_in_ready): one transfer per scan with the
//    millisecond time, eight active-low pin levels and an optional load.
//  - Event channel (o_out_valid / i_out_ready): one transfer per event, in
//    channel order then overload; o_last_event marks a scan's final event.
//    A scan that raises no event gives no transfer.
//  - Config port: i_cfg_we writes i_cfg_data to register i_cfg_index
//    (0 debounce ms, 1 overload threshold, 2 hysteresis); index 3 ignored.
//  - A scan's events pass from the input register through the queue to
//    the output register, which sends one event per cycle while i_out_ready
//    is high; a scan raises up to nine events.
//  - The input register takes a new scan while earlier events still drain.
//  - Stall: while i_out_ready is low the held event stays put, the queue
//    fills and o_in_ready drops once a scan waits in the input register.
//  - Reset (synchronous, active low): all levels released, change times 0,
//    overload off, registers at 50 ms / 300000 g / 100 g, queue empty.
`default_nettype none
module debounced_input_event_scanner_unit
    import dbes_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic        [1:0]  i_cfg_index,
    input  wire logic        [23:0] i_cfg_data,
    // scan input
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic        [31:0] i_now_ms,
    input  wire logic        [7:0]  i_pin_levels,
    input  wire logic               i_load_ready,
    input  wire logic signed [31:0] i_load_grams,
    // event output
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic             [3:0]  o_event_code,
    output logic signed      [31:0] o_event_value,
    output logic                    o_last_event
);
    // configuration registers
    logic [15:0] r_debounce;
    logic [23:0] r_thr;
    logic [15:0] r_hyst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= 16'd50;
            r_thr      <= 24'd300000;
            r_hyst     <= 16'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:   r_debounce <= i_cfg_data[15:0];
                CFG_THRESHOLD:  r_thr      <= i_cfg_data;
                CFG_HYSTERESIS: r_hyst     <= i_cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // input register
    logic               r_in_valid;
    logic        [31:0] r_now;
    logic        [7:0]  r_pins;
    logic               r_load_ready;
    logic signed [31:0] r_load;
    logic               proc_fire, q_free, in_fire;

    assign proc_fire  = r_in_valid && q_free;
    assign o_in_ready = !r_in_valid || proc_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_now        <= i_now_ms;
            r_pins       <= i_pin_levels;
            r_load_ready <= i_load_ready;
            r_load       <= i_load_grams;
        end
    end

    // debounce lanes
    logic [NUM_CH-1:0] ch_edge, ch_level;

    for (genvar g = 0; g < NUM_CH; g++) begin : g_chan
        dbes_chan u_chan (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (proc_fire),
            .i_level    (r_pins[g]),
            .i_now      (r_now),
            .i_debounce (r_debounce),
            .o_edge     (ch_edge[g]),
            .o_stable   (ch_level[g])
        );
    end

    // overload detector
    logic ovl_on, ovl_off;

    dbes_ovl u_ovl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (proc_fire),
        .i_load_ready (r_load_ready),
        .i_load       (r_load),
        .i_thr        (r_thr),
        .i_hyst       (r_hyst),
        .o_on         (ovl_on),
        .o_off        (ovl_off)
    );

    // releases only count on channels that report them
    t_scan_events scan;

    always_comb begin
        scan.mask   = {ovl_on | ovl_off, ch_edge & (~ch_level | CH_REPORTS_HIGH)};
        scan.levels = ch_level;
        scan.ovl_on = ovl_on;
        scan.load   = r_load;
    end

    dbes_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (proc_fire),
        .i_scan  (scan),
        .o_free  (q_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_code  (o_event_code),
        .o_value (o_event_value),
        .o_last  (o_last_event)
    );
endmodule
`default_nettype wire

FILE: tb/dbes_event_checker.sv
// Event checker for the debounced input event scanner: watches the scan, event
// and register-write ports, predicts every event and compares. Uses dbes_pkg.
module dbes_event_checker
    import dbes_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic        [1:0]  i_cfg_index,
    input  wire logic        [23:0] i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic        [31:0] i_now_ms,
    input  wire logic        [7:0]  i_pin_levels,
    input  wire logic               i_load_ready,
    input  wire logic signed [31:0] i_load_grams,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic        [3:0]  i_event_code,
    input  wire logic signed [31:0] i_event_value,
    input  wire logic               i_last_event,
    output int                      o_pending,
    output int                      o_errors
);

    localparam int CH_EMERG = 4;
    localparam int CH_DOOR  = 5;

    typedef struct {
        logic [3:0]         code;
        logic signed [31:0] value;
        logic               last;
    } t_event;

    t_event events_due[$];
    int     error_count = 0;
    int     due_count   = 0;

    logic [15:0]       db_window;
    logic [23:0]       threshold_g;
    logic [15:0]       hysteresis_g;
    logic [NUM_CH-1:0] stable_lvl;
    logic [NUM_CH-1:0] cand_lvl;
    logic [31:0]       changed_at [NUM_CH];
    logic              overload_on;

    assign o_pending = due_count;
    assign o_errors  = error_count;

    task automatic report_fault(input string msg);
        $display("%0t checker: %s", $time, msg);
        error_count++;
    endtask

    task automatic push_event(input logic [3:0] code, input logic signed [31:0] value);
        t_event ev;
        ev.code  = code;
        ev.value = value;
        ev.last  = 1'b0;
        events_due.push_back(ev);
    endtask

    // Debounce every lane, then the overload detector; the final event of the
    // scan carries the last flag.
    task automatic predict_scan(input logic [31:0] now, input logic [7:0] pins,
                                input logic ready, input logic signed [31:0] grams);
        int         raised;
        logic       lvl;
        logic [3:0] code;
        longint     load;
        longint     on_pt;
        longint     off_pt;
        raised = 0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            lvl = pins[ch];
            if (lvl != cand_lvl[ch]) begin
                cand_lvl[ch]   = lvl;
                changed_at[ch] = now;
            end else if (lvl != stable_lvl[ch] &&
                         (now - changed_at[ch]) >= {16'd0, db_window}) begin
                stable_lvl[ch] = lvl;
                case (ch)
                    0, 1:     code = EV_REQ_GROUND;
                    2, 3:     code = EV_REQ_FLOOR2;
                    CH_EMERG: code = lvl ? EV_EMERG_OFF : EV_EMERG_ON;
                    CH_DOOR:  code = lvl ? EV_DOOR_OPEN : EV_DOOR_CLOSED;
                    6:        code = EV_ARRIVE_GROUND;
                    default:  code = EV_ARRIVE_FLOOR2;
                endcase
                // buttons and reeds stay silent on release
                if (!lvl || ch == CH_EMERG || ch == CH_DOOR) begin
                    push_event(code, 32'sd0);
                    raised++;
                end
            end
        end
        if (ready) begin
            load   = longint'(grams);
            on_pt  = longint'(threshold_g);
            off_pt = on_pt - longint'(hysteresis_g);   // may go negative
            if (!overload_on && load >= on_pt) begin
                overload_on = 1'b1;
                push_event(EV_OVERLOAD_ON, grams);
                raised++;
            end else if (overload_on && load < off_pt) begin
                overload_on = 1'b0;
                push_event(EV_OVERLOAD_OFF, grams);
                raised++;
            end
        end
        if (raised > 0)
            events_due[events_due.size() - 1].last = 1'b1;
    endtask

    task automatic check_event();
        t_event ev;
        if (events_due.size() == 0) begin
            report_fault($sformatf("unexpected event, code %0d", i_event_code));
        end else begin
            ev = events_due.pop_front();
            if (i_event_code !== ev.code)
                report_fault($sformatf("event code %0d, expected %0d",
                                       i_event_code, ev.code));
            if (i_event_value !== ev.value)
                report_fault($sformatf("event value %0d, expected %0d (code %0d)",
                                       i_event_value, ev.value, ev.code));
            if (i_last_event !== ev.last)
                report_fault($sformatf("last flag %b, expected %b (code %0d)",
                                       i_last_event, ev.last, ev.code));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            db_window    = 16'd50;
            threshold_g  = 24'd300000;
            hysteresis_g = 16'd100;
            stable_lvl   = '1;
            cand_lvl     = '1;
            overload_on  = 1'b0;
            for (int ch = 0; ch < NUM_CH; ch++)
                changed_at[ch] = 32'd0;
            events_due.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_event();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE:   db_window    = i_cfg_data[15:0];
                    CFG_THRESHOLD:  threshold_g  = i_cfg_data;
                    CFG_HYSTERESIS: hysteresis_g = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_scan(i_now_ms, i_pin_levels, i_load_ready, i_load_grams);
        end
        due_count <= events_due.size();
    end

endmodule

FILE: tb/tb_debounced_input_event_scanner_unit.sv
// Testbench top for the debounced input event scanner: clock, reset, scan and
// register stimulus, receiver stalls and the verdict. Needs dbes_pkg, the RTL
// and dbes_event_checker.
module tb_debounced_input_event_scanner_unit;
    import dbes_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // unused index, writes ignored
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;         // margin for a scan still in the pipeline
    localparam int PHASE_SCANS   = 56;
    localparam int PHASES        = 6;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic        [1:0]  i_cfg_index   = CFG_DEBOUNCE;
    logic        [23:0] i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic        [31:0] i_now_ms      = '0;
    logic        [7:0]  i_pin_levels  = 8'hFF;
    logic               i_load_ready  = 1'b0;
    logic signed [31:0] i_load_grams  = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic        [3:0]  o_event_code;
    logic signed [31:0] o_event_value;
    logic               o_last_event;

    int events_pending;
    int fault_count;
    int cycle_count   = 0;
    int send_idle_pct = 25;
    int recv_idle_pct = 51;

    // Register values as last written, used only to aim the stimulus
    int cur_db  = 50;
    int cur_thr = 300000;
    int cur_hys = 100;

    // Running scan state: the time base and the pins as the random walk left them
    logic [31:0] clock_ms  = '0;
    logic [7:0]  pin_state = 8'hFF;

    always #4 i_clk = ~i_clk;

    debounced_input_event_scanner_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_now_ms      (i_now_ms),
        .i_pin_levels  (i_pin_levels),
        .i_load_ready  (i_load_ready),
        .i_load_grams  (i_load_grams),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_code  (o_event_code),
        .o_event_value (o_event_value),
        .o_last_event  (o_last_event)
    );

    dbes_event_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_now_ms      (i_now_ms),
        .i_pin_levels  (i_pin_levels),
        .i_load_ready  (i_load_ready),
        .i_load_grams  (i_load_grams),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_event_code  (o_event_code),
        .i_event_value (o_event_value),
        .i_last_event  (o_last_event),
        .o_pending     (events_pending),
        .o_errors      (fault_count)
    );

    // Event receiver: ready drops at random at the current stall rate
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("debounced_input_event_scanner_unit: mismatch");
            $finish;
        end
    end

    // One scan transfer. A random gap may come first; valid then holds with
    // the payload steady until the transfer. Returns in the step of the
    // transfer without touching valid, so back-to-back scans keep it high.
    task automatic send_scan(input logic [31:0] now, input logic [7:0] pins,
                             input logic ready, input logic signed [31:0] grams);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_now_ms     <= now;
        i_pin_levels <= pins;
        i_load_ready <= ready;
        i_load_grams <= grams;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Hold off the sender until every predicted event has been taken, then
    // give a scan that raises nothing time to clear the pipeline as well.
    // The pending count is registered, hence the first wait.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (events_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; the idle wait after it keeps write enable from being
    // raised again in the step where it drops.
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random scan. Mostly well-formed: time moves by amounts around the
    // debounce time and pins hold, so changes get through to stable edges.
    // The rest is bounce, whole random pin sets and big time jumps.
    task automatic random_scan();
        int unsigned pick;
        int unsigned step;
        longint      load;
        logic        ready;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            step = 0;
        else if (pick < 70)
            step = $urandom_range(0, 2 * cur_db + 2);
        else if (pick < 82)
            step = cur_db - $urandom_range(0, 1);   // just short of, or at, the limit
        else if (pick < 95)
            step = $urandom_range(0, 5);
        else
            step = $urandom();
        clock_ms = clock_ms + step;

        pick = $urandom_range(0, 99);
        if (pick < 20)
            pin_state = pin_state ^ 8'(1 << $urandom_range(0, 7));
        else if (pick < 28)
            pin_state = pin_state ^ 8'($urandom());
        else if (pick < 33)
            pin_state = 8'($urandom());

        ready = ($urandom_range(0, 2) != 0);
        pick  = $urandom_range(0, 99);
        if (pick < 65) begin
            // straddle the hysteresis band
            load = longint'(cur_thr) - cur_hys - 2 + $urandom_range(0, cur_hys + 4);
        end else if (pick < 80) begin
            case ($urandom_range(0, 3))
                0:       load = cur_thr;
                1:       load = cur_thr - 1;
                2:       load = cur_thr - cur_hys;
                default: load = cur_thr - cur_hys - 1;
            endcase
        end else if (pick < 92) begin
            load = longint'(int'($urandom()));
        end else begin
            case ($urandom_range(0, 3))
                0:       load = 64'sh7FFF_FFFF;
                1:       load = -64'sh8000_0000;
                2:       load = 0;
                default: load = -1;
            endcase
        end
        send_scan(clock_ms, pin_state, ready, 32'(load));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset registers: 50 ms debounce, 300000 g, 100 g.
        send_scan(32'd0,  8'hFF, 1'b0, 32'sd0);        // matches reset state
        send_scan(32'd10, 8'h00, 1'b1, 32'sd299999);   // all lanes change; load under
        send_scan(32'd59, 8'h00, 1'b0, 32'sd0);        // one ms short
        send_scan(32'd60, 8'h00, 1'b1, 32'sd300000);   // every lane plus overload on
        send_scan(32'd70, 8'hFF, 1'b1, 32'sd299900);   // release starts; at off point
        send_scan(32'd119, 8'hFF, 1'b0, 32'sd0);
        send_scan(32'd120, 8'hFF, 1'b1, 32'sd299899);  // of the lanes only emergency and door speak; overload off
        send_scan(32'd130, 8'hFF, 1'b0, 32'sh7FFF_FFFF); // no sample, ignored
        send_scan(32'd140, 8'hFF, 1'b1, 32'sh7FFF_FFFF);
        send_scan(32'd150, 8'hFF, 1'b1, 32'sh8000_0000);
        // time wraps between change and acceptance
        send_scan(32'hFFFF_FFF0, 8'hEF, 1'b1, -32'sd1);
        send_scan(32'h0000_0022, 8'hEF, 1'b0, 32'sd0);
        send_scan(32'h0000_0023, 8'hCE, 1'b0, 32'sd0);
        send_scan(32'h0000_0055, 8'hCE, 1'b0, 32'sd0);
        send_scan(32'h0000_0060, 8'hFF, 1'b0, 32'sd0);
        send_scan(32'h0000_0092, 8'hFF, 1'b0, 32'sd0);  // button release is silent
        send_scan(32'h0000_0093, 8'h7F, 1'b0, 32'sd0);
        send_scan(32'h0000_00C5, 8'h7F, 1'b1, 32'sh00FF_FFFF);
        send_scan(32'h0000_00C6, 8'h7F, 1'b1, 32'sd0);
        clock_ms  = 32'h0000_00C6;
        pin_state = 8'h7F;
        settle();

        // Random part: each phase is a register setting, with the idle pattern
        // moving from sender-light to receiver-light to none.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0, 1: begin send_idle_pct = 25; recv_idle_pct = 51; end
                2, 3: begin send_idle_pct = 51; recv_idle_pct = 25; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (phase)
                0:       begin cur_db = 3;     cur_thr = 1000;     cur_hys = 100;   end
                1:       begin cur_db = 0;     cur_thr = 0;        cur_hys = 0;     end
                2:       begin cur_db = 65535; cur_thr = 16777215; cur_hys = 65535; end
                3:       begin cur_db = 20;    cur_thr = 50;       cur_hys = 65535; end
                4:       begin cur_db = 1;     cur_thr = 300000;   cur_hys = 100;   end
                default: begin cur_db = 7;     cur_thr = 8388608;  cur_hys = 1;     end
            endcase
            // junk in the upper bits checks the masking of the narrow registers
            write_reg(CFG_DEBOUNCE,   {8'($urandom()), 16'(cur_db)});
            write_reg(CFG_THRESHOLD,  24'(cur_thr));
            write_reg(CFG_HYSTERESIS, {8'($urandom()), 16'(cur_hys)});
            if (phase == 3)
                write_reg(CFG_SPARE, 24'($urandom()));
            for (int n = 0; n < PHASE_SCANS; n++) begin
                random_scan();
                if ($urandom_range(0, 39) == 0)
                    settle();   // sender waits for the event queue to empty
            end
            settle();
        end

        if (fault_count == 0)
            $display("debounced_input_event_scanner_unit: match");
        else
            $display("debounced_input_event_scanner_unit: mismatch");
        $finish;
    end

endmodule
